// ===== design/ile_pkg.sv =====
package ile_pkg;

	// Request codes
	localparam logic [2:0] FUNC_GET  = 3'd0;
	localparam logic [2:0] FUNC_HEAD = 3'd1;
	localparam logic [2:0] FUNC_TAIL = 3'd2;
	localparam logic [2:0] FUNC_AT   = 3'd3;
	localparam logic [2:0] FUNC_DEL  = 3'd4;

	// Result status codes
	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;

	// Value returned by anything but a valid get
	localparam logic signed [31:0] READ_NONE = -32'sd1;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [15:0] index;
		logic signed [31:0] value;
	} req_beat_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
		logic [4:0]         length_now;
	} rsp_beat_t;

endpackage

// ===== design/ile_ram.sv =====
module ile_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/indexed_list_engine.sv =====
// Ordered list of signed 32-bit values held in a single RAM of CAPACITY words.
// The request channel (req_valid / req_stall / req) carries one operation per
// beat: get, insert at head, insert at tail, insert before an index, or delete
// at an index. Each request returns exactly one beat on the response channel
// (rsp_valid / rsp_stall / rsp) with the read value, a status and the length.
// One request is in work at a time; req_stall is high until it finishes, and
// the next request can be taken in the cycle after its response beat is loaded.
// A get waits for its registered RAM read, and an invalid or full request
// goes straight to its response. An insert at position p shifts the entries
// from p upward and then writes the new value; a delete at position p shifts
// the entries above p down, or just drops the last entry. The shift loop
// moves one entry per cycle through the RAM's single write port, each
// registered read pipelined with the write of the entry before it.
// Reset empties the list at once; the RAM contents need no clearing since
// only positions below the length are ever read.
// When the receiver holds rsp_stall, the response register keeps its beat,
// and a finished request waits in its final state until the register frees.
module indexed_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ile_pkg::req_beat_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ile_pkg::rsp_beat_t rsp
);

	import ile_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_GETW = 3'd1;
	localparam logic [2:0] S_UP   = 3'd2;
	localparam logic [2:0] S_DN   = 3'd3;
	localparam logic [2:0] S_PUT  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]         state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic [AW-1:0]      k_q, k_d;
	logic [AW-1:0]      pos_q, pos_d;
	logic signed [31:0] val_q, val_d;
	logic signed [31:0] rd_q, rd_d;
	logic [1:0]         stat_q, stat_d;
	logic               rsp_valid_q;
	rsp_beat_t          rsp_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [31:0]        ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [31:0]        ram_rdata;

	logic               accept;
	logic               rsp_free;
	logic               load_rsp;

	ile_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign load_rsp  = (state_q == S_FIN) && rsp_free;

	// Decode, shift sequencing and RAM access
	always_comb begin
		logic              neg;
		logic [15:0]       idx_u;
		logic [15:0]       cnt16;
		logic              full;
		logic              ins_go;
		logic [AW-1:0]     ins_pos;
		logic [AW-1:0]     cnt_a;
		logic [CW:0]       k_plus2;

		state_d   = state_q;
		count_d   = count_q;
		k_d       = k_q;
		pos_d     = pos_q;
		val_d     = val_q;
		rd_d      = rd_q;
		stat_d    = stat_q;
		ram_we    = 1'b0;
		ram_waddr = k_q;
		ram_wdata = ram_rdata;
		ram_raddr = k_q;

		neg     = req.index[15];
		idx_u   = req.index;
		cnt16   = 16'(count_q);
		full    = (count_q == CW'(CAPACITY));
		ins_go  = 1'b0;
		ins_pos = '0;
		cnt_a   = AW'(count_q);
		k_plus2 = (CW+1)'(k_q) + (CW+1)'(2);

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					rd_d   = READ_NONE;
					stat_d = STAT_DONE;
					val_d  = req.value;
					case (req.func)
						FUNC_GET: begin
							if (neg || idx_u >= cnt16) begin
								stat_d  = STAT_BAD_INDEX;
								state_d = S_FIN;
							end else begin
								ram_raddr = idx_u[AW-1:0];
								state_d   = S_GETW;
							end
						end
						FUNC_HEAD: begin
							if (full) begin
								stat_d  = STAT_FULL;
								state_d = S_FIN;
							end else begin
								ins_go  = 1'b1;
								ins_pos = '0;
							end
						end
						FUNC_TAIL: begin
							if (full) begin
								stat_d  = STAT_FULL;
								state_d = S_FIN;
							end else begin
								ins_go  = 1'b1;
								ins_pos = cnt_a;
							end
						end
						FUNC_AT: begin
							if (neg || idx_u > cnt16) begin
								stat_d  = STAT_BAD_INDEX;
								state_d = S_FIN;
							end else if (full) begin
								stat_d  = STAT_FULL;
								state_d = S_FIN;
							end else begin
								ins_go  = 1'b1;
								ins_pos = idx_u[AW-1:0];
							end
						end
						FUNC_DEL: begin
							if (neg || idx_u >= cnt16) begin
								stat_d  = STAT_BAD_INDEX;
								state_d = S_FIN;
							end else if (idx_u == cnt16 - 16'd1) begin
								// last entry: just drop it
								count_d = count_q - CW'(1);
								state_d = S_FIN;
							end else begin
								ram_raddr = idx_u[AW-1:0] + AW'(1);
								k_d       = idx_u[AW-1:0];
								state_d   = S_DN;
							end
						end
						default: begin
							stat_d  = STAT_BAD_INDEX;
							state_d = S_FIN;
						end
					endcase
					// Start an insert: shift the tail up unless it lands at the end
					if (ins_go) begin
						pos_d = ins_pos;
						if (cnt_a == ins_pos) begin
							state_d = S_PUT;
						end else begin
							ram_raddr = cnt_a - AW'(1);
							k_d       = cnt_a;
							state_d   = S_UP;
						end
					end
				end
			end
			S_GETW: begin
				rd_d    = ram_rdata;
				state_d = S_FIN;
			end
			S_UP: begin
				// write entry k-1 into k, fetch k-2 while the shift goes on
				ram_we    = 1'b1;
				ram_waddr = k_q;
				ram_wdata = ram_rdata;
				if ((k_q - AW'(1)) != pos_q) begin
					ram_raddr = k_q - AW'(2);
					k_d       = k_q - AW'(1);
				end else begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = val_q;
				count_d   = count_q + CW'(1);
				state_d   = S_FIN;
			end
			S_DN: begin
				// write entry k+1 into k, fetch k+2 while the shift goes on
				ram_we    = 1'b1;
				ram_waddr = k_q;
				ram_wdata = ram_rdata;
				if (k_plus2 < (CW+1)'(count_q)) begin
					ram_raddr = k_q + AW'(2);
					k_d       = k_q + AW'(1);
				end else begin
					count_d = count_q - CW'(1);
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and the response beat
	always_ff @(posedge clk) begin
		k_q    <= k_d;
		pos_q  <= pos_d;
		val_q  <= val_d;
		rd_q   <= rd_d;
		stat_q <= stat_d;
		if (load_rsp) begin
			rsp_q.read_value <= rd_q;
			rsp_q.status     <= stat_q;
			rsp_q.length_now <= 5'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== verif/indexed_list_engine_tb.sv =====
module indexed_list_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ile_pkg::*;

	localparam int LIST_CAP = 16;
	localparam int RANDOM_ITEMS = 1280;
	// a shift through the whole list plus the fixed overhead
	localparam int DRAIN_CYCLES = LIST_CAP + 8;
	localparam int WATCHDOG_LIMIT = 400;

	// codes the block does not implement
	localparam logic [2:0] FUNC_SPARE_A = 3'd5;
	localparam logic [2:0] FUNC_SPARE_B = 3'd6;
	localparam logic [2:0] FUNC_SPARE_C = 3'd7;

	// stimulus mixes
	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIX   = 2;

	// receiver stall patterns
	localparam int STALL_NONE     = 0;
	localparam int STALL_RANDOM   = 1;
	localparam int STALL_PERIODIC = 2;
	localparam int STALL_LONG     = 3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_beat_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_beat_t rsp;

	req_beat_t pending_reqs[$];
	rsp_beat_t list_results[$];

	// predicted list contents
	logic signed [31:0] list_mem [LIST_CAP];
	int list_len = 0;

	// length seen by the generator, used only to aim indexes
	int gen_len = 0;

	int mismatch_count = 0;
	int idle_cycles = 0;
	int send_gap = 0;
	int burst_left = 1;
	int stall_mode = STALL_NONE;
	int stall_left = 0;
	int stall_tick = 0;

	indexed_list_engine #(
		.CAPACITY(LIST_CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	// apply one request to the predicted list and return its response
	function automatic rsp_beat_t apply_list_op(req_beat_t r);
		rsp_beat_t o;
		int pos;
		bit do_put;
		int put_pos;
		o.read_value = READ_NONE;
		o.status = STAT_DONE;
		pos = r.index;
		do_put = 1'b0;
		put_pos = 0;
		case (r.func)
		FUNC_GET: begin
			if (pos < 0 || pos >= list_len)
				o.status = STAT_BAD_INDEX;
			else
				o.read_value = list_mem[pos];
		end
		FUNC_HEAD, FUNC_TAIL: begin
			if (list_len >= LIST_CAP)
				o.status = STAT_FULL;
			else begin
				do_put = 1'b1;
				put_pos = (r.func == FUNC_HEAD) ? 0 : list_len;
			end
		end
		FUNC_AT: begin
			// a bad index wins over a full store
			if (pos < 0 || pos > list_len)
				o.status = STAT_BAD_INDEX;
			else if (list_len >= LIST_CAP)
				o.status = STAT_FULL;
			else begin
				do_put = 1'b1;
				put_pos = pos;
			end
		end
		FUNC_DEL: begin
			if (pos < 0 || pos >= list_len)
				o.status = STAT_BAD_INDEX;
			else begin
				for (int k = pos; k + 1 < list_len; k++)
					list_mem[k] = list_mem[k + 1];
				list_len--;
			end
		end
		default: o.status = STAT_BAD_INDEX;
		endcase
		// shift the tail back one place and drop the new entry in
		if (do_put) begin
			for (int k = list_len; k > put_pos; k--)
				list_mem[k] = list_mem[k - 1];
			list_mem[put_pos] = r.value;
			list_len++;
		end
		o.length_now = 5'(list_len);
		return o;
	endfunction

	task automatic queue_req(logic [2:0] f, int idx, logic [31:0] v);
		req_beat_t r;
		r.func = f;
		r.index = 16'(idx);
		r.value = v;
		pending_reqs.push_back(r);
		// track the length so later indexes land inside the list
		case (f)
		FUNC_HEAD, FUNC_TAIL: if (gen_len < LIST_CAP) gen_len++;
		FUNC_AT: if (idx >= 0 && idx <= gen_len && gen_len < LIST_CAP) gen_len++;
		FUNC_DEL: if (idx >= 0 && idx < gen_len) gen_len--;
		default: ;
		endcase
	endtask

	function automatic int inside_idx();
		return (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);
	endfunction

	function automatic logic [31:0] entry_value();
		case ($urandom_range(0, 19))
		0: return 32'h7fff_ffff;
		1: return 32'h8000_0000;
		2: return 32'h0;
		3: return 32'hffff_ffff;
		default: return $urandom;
		endcase
	endfunction

	// stimulus and end of run
	initial begin
		int mode;
		int mode_left;
		int roll;
		logic [2:0] f;
		logic signed [15:0] rnd_idx;

		// empty list: every indexed access is out of range
		queue_req(FUNC_GET, 0, 32'h0);
		queue_req(FUNC_DEL, 0, 32'h0);
		queue_req(FUNC_AT, 1, 32'h1234_5678);
		queue_req(FUNC_AT, -32768, 32'hffff_ffff);
		queue_req(FUNC_SPARE_A, 0, 32'h0);
		queue_req(FUNC_SPARE_B, -1, 32'hffff_ffff);
		queue_req(FUNC_SPARE_C, 32767, 32'h7fff_ffff);
		// build a short list through every insert kind
		queue_req(FUNC_AT, 0, 32'h0);
		queue_req(FUNC_HEAD, 0, 32'h7fff_ffff);
		queue_req(FUNC_TAIL, 0, 32'h8000_0000);
		queue_req(FUNC_AT, 3, 32'hffff_ffff);
		queue_req(FUNC_AT, 2, 32'h5555_aaaa);
		// reads at both ends and just past them
		queue_req(FUNC_GET, 0, 32'h0);
		queue_req(FUNC_GET, 4, 32'h0);
		queue_req(FUNC_GET, 5, 32'h0);
		queue_req(FUNC_GET, -1, 32'h0);
		queue_req(FUNC_GET, 32767, 32'h0);
		// deletes out of range, at the tail, head and middle
		queue_req(FUNC_DEL, 32767, 32'h0);
		queue_req(FUNC_DEL, -1, 32'h0);
		queue_req(FUNC_DEL, 4, 32'h0);
		queue_req(FUNC_DEL, 0, 32'h0);
		queue_req(FUNC_DEL, 1, 32'h0);
		queue_req(FUNC_GET, 0, 32'h0);

		// random phases that fill, drain or churn the list
		mode = MODE_FILL;
		mode_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (mode_left == 0) begin
				mode = $urandom_range(MODE_FILL, MODE_MIX);
				mode_left = $urandom_range(20, 50);
			end
			mode_left--;
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				f = 3'($urandom_range(0, 7));
				rnd_idx = 16'($urandom);
				queue_req(f, int'(rnd_idx), $urandom);
			end else if (mode == MODE_FILL) begin
				if (roll < 70) begin
					case ($urandom_range(0, 2))
					0: queue_req(FUNC_HEAD, inside_idx(), entry_value());
					1: queue_req(FUNC_TAIL, inside_idx(), entry_value());
					default: queue_req(FUNC_AT, $urandom_range(0, gen_len), entry_value());
					endcase
				end else if (roll < 85)
					queue_req(FUNC_GET, inside_idx(), entry_value());
				else
					queue_req(FUNC_DEL, inside_idx(), entry_value());
			end else if (mode == MODE_DRAIN) begin
				if (roll < 60)
					queue_req(FUNC_DEL, inside_idx(), entry_value());
				else if (roll < 80)
					queue_req(FUNC_GET, inside_idx(), entry_value());
				else
					queue_req(FUNC_TAIL, 0, entry_value());
			end else begin
				f = 3'($urandom_range(FUNC_GET, FUNC_DEL));
				if ($urandom_range(0, 3) == 0)
					queue_req(f, gen_len + $urandom_range(0, 1), entry_value());
				else
					queue_req(f, $urandom_range(0, gen_len), entry_value());
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every beat to go out and every response to come back
		while (pending_reqs.size() > 0 || req_valid || list_results.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (list_results.size() > 0) begin
			$error("%0d responses never arrived", list_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// request driver: bursts of beats separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			// predict the response for the beat taken at this edge
			if (req_valid && !req_stall)
				list_results.push_back(apply_list_op(req));
			// advance once the current beat is gone
			if (!req_valid || !req_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		rsp_beat_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			// check the beat taken at this edge against the oldest prediction
			if (rsp_valid && !rsp_stall) begin
				if (list_results.size() == 0) begin
					$error("response with nothing outstanding");
					mismatch_count++;
				end else begin
					want = list_results.pop_front();
					if (rsp.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d", want.read_value,
							rsp.read_value);
						mismatch_count++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatch_count++;
					end
					if (rsp.length_now !== want.length_now) begin
						$error("length_now: expected %0d, got %0d", want.length_now,
							rsp.length_now);
						mismatch_count++;
					end
				end
			end
			// pick a new stall pattern now and then
			if (stall_left == 0) begin
				stall_mode = $urandom_range(STALL_NONE, STALL_LONG);
				stall_left = $urandom_range(40, 120);
			end
			stall_left--;
			stall_tick++;
			case (stall_mode)
			STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
			STALL_PERIODIC: rsp_stall <= (stall_tick % 7) < 4;
			STALL_LONG: rsp_stall <= (stall_tick % 14) < 12;
			default: rsp_stall <= 1'b0;
			endcase
		end
	end

	// watchdog: end the run if no beat moves for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== filelist.f =====
design/ile_pkg.sv
design/ile_ram.sv
design/indexed_list_engine.sv
verif/indexed_list_engine_tb.sv
